### src/wve_pkg.sv
// Shared types, widths and codes for the wind vector estimator.
package wve_pkg;

   // Shared multiply-accumulate unit
   localparam int MUL_W  = 27;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 60;
   localparam int SHL_N  = 16;

   // Shared square-root unit
   localparam int SQ_IN_W  = 52;
   localparam int SQ_OUT_W = SQ_IN_W / 2;

   // Shared divider unit
   localparam int DIV_N_W = 31;
   localparam int DIV_D_W = 17;

   // Register indexes
   localparam logic [1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_TURN    = 2'd1;
   localparam logic [1:0] CSR_MARGIN  = 2'd2;
   localparam logic [1:0] CSR_GAIN    = 2'd3;

   // Register reset values
   localparam logic [15:0] TIMEOUT_RST = 16'd1000;
   localparam logic [15:0] TURN_RST    = 16'd3277;
   localparam logic [14:0] MARGIN_RST  = 15'd5120;
   localparam logic [15:0] GAIN_RST    = 16'd1638;

   // Outcome codes
   localparam logic [1:0] OUT_REBASE = 2'd0;
   localparam logic [1:0] OUT_SMALL  = 2'd1;
   localparam logic [1:0] OUT_REJECT = 2'd2;
   localparam logic [1:0] OUT_BLEND  = 2'd3;

   typedef struct packed {
      logic                    valid;
      logic                    clr;
      logic                    neg;
      logic                    shl;
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mac_cmd_type;

   typedef struct packed {
      logic               start;
      logic [SQ_IN_W-1:0] x;
   } sqrt_req_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

endpackage

### src/wind_vector_estimator_top.sv
// Wind vector estimator top level: sequencer, state and shared units.
//
// Usage: each transfer on the req_ channel carries a heading unit vector
// (Q1.14), a ground velocity (Q8.8) and a millisecond time. Every request
// yields exactly one transfer on the rsp_ channel with the wind estimate
// (Q8.8), its horizontal magnitude and an outcome code. The csr_ channel
// writes the four tuning registers and is always ready; write it only while
// no request is in flight.
// A stale-gap rebase goes from the check state straight to the result, and a
// too-small turn ends after the turn test. The full path is set by the shared
// square-root unit (six calls) and the shared divider (up to five calls), both
// one bit per cycle. A new request is taken only in idle, so the block takes
// no new request before it is through with the last. The result sits in an
// output register: the next request is taken while it waits, and the
// sequencer holds a finished item only when a previous result has still not
// been taken.
// Reset: registers return to defaults, state and wind clear to zero, and
// the block is ready on the next cycle.
module wind_vector_estimator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_head_north,
   input  logic signed [15:0] req_head_east,
   input  logic signed [15:0] req_head_down,
   input  logic signed [15:0] req_vel_north,
   input  logic signed [15:0] req_vel_east,
   input  logic signed [15:0] req_vel_down,
   input  logic        [31:0] req_now_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_wind_north,
   output logic signed [15:0] rsp_wind_east,
   output logic signed [15:0] rsp_wind_down,
   output logic        [15:0] rsp_wind_horizontal,
   output logic        [1:0]  rsp_outcome,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [1:0]  csr_index,
   input  logic        [15:0] csr_data
);
   import wve_pkg::*;

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_CHECK   = 5'd1;
   localparam logic [4:0] ST_DHSQ    = 5'd2;
   localparam logic [4:0] ST_MT      = 5'd3;
   localparam logic [4:0] ST_SQ_DH   = 5'd4;
   localparam logic [4:0] ST_DVSQ    = 5'd5;
   localparam logic [4:0] ST_SQ_DV   = 5'd6;
   localparam logic [4:0] ST_DIV_SOG = 5'd7;
   localparam logic [4:0] ST_UV_LEN  = 5'd8;
   localparam logic [4:0] ST_UV_SQ   = 5'd9;
   localparam logic [4:0] ST_UV_DX   = 5'd10;
   localparam logic [4:0] ST_UV_DY   = 5'd11;
   localparam logic [4:0] ST_CT      = 5'd12;
   localparam logic [4:0] ST_ST      = 5'd13;
   localparam logic [4:0] ST_R       = 5'd14;
   localparam logic [4:0] ST_C       = 5'd15;
   localparam logic [4:0] ST_WSQ     = 5'd16;
   localparam logic [4:0] ST_SQ_W    = 5'd17;
   localparam logic [4:0] ST_LIM     = 5'd18;
   localparam logic [4:0] ST_CSQ     = 5'd19;
   localparam logic [4:0] ST_BLEND   = 5'd20;
   localparam logic [4:0] ST_UPD     = 5'd21;
   localparam logic [4:0] ST_HSQ     = 5'd22;
   localparam logic [4:0] ST_SQ_H    = 5'd23;
   localparam logic [4:0] ST_FIN     = 5'd24;

   localparam logic signed [MUL_W-1:0] ONE_Q14  = MUL_W'(16384);
   localparam logic signed [MUL_W-1:0] SH_Q12   = MUL_W'(4096);
   localparam logic signed [MUL_W-1:0] ONE_Q15  = MUL_W'(32768);
   localparam logic signed [23:0]      W_MAX    = 24'sh7FFFFF;
   localparam logic signed [23:0]      W_MIN    = -24'sh800000;

   // Control and architectural state
   logic [4:0]         state_ff;
   logic [2:0]         cnt_ff;
   logic [1:0]         comp_ff;
   logic               sel_ff;
   logic               rsp_valid_ff;
   logic [15:0]        timeout_ff, turn_ff, gain_ff;
   logic [14:0]        margin_ff;
   logic signed [15:0] lh_ff [3];
   logic signed [15:0] lv_ff [3];
   logic signed [23:0] w_ff [3];
   logic [31:0]        lt_ff;
   logic [15:0]        hw_ff;

   // Working registers
   logic signed [15:0] hin_ff [3];
   logic signed [15:0] vin_ff [3];
   logic [31:0]        now_ff;
   logic [35:0]        dhsq_ff;
   logic [16:0]        dhl_ff, len_ff;
   logic [23:0]        sog_ff;
   logic signed [15:0] ax_ff, ay_ff, bx_ff, by_ff, ct_ff, st_ff;
   logic [32:0]        r_ff;
   logic signed [38:0] c_ff [3];
   logic [26:0]        lim_ff;
   logic [1:0]         outcome_ff;
   logic signed [15:0] rsp_wn_ff, rsp_we_ff, rsp_wd_ff;
   logic [15:0]        rsp_hw_ff;
   logic [1:0]         rsp_out_ff;

   // Derived values
   logic signed [16:0] dh [3];
   logic signed [16:0] dv [3];
   logic signed [16:0] sm_h [3];
   logic signed [16:0] sm_v [3];
   logic signed [ACC_W-1:0] acc;
   logic [1:0]         ki;
   logic [2:0]         n_ops;
   logic               is_mac, mac_done, turn_small, lim_fail, can_load;
   logic signed [MUL_W-1:0] op_a, op_b;
   logic               op_neg, op_shl;
   mac_cmd_type        mac_cmd;
   sqrt_req_type       sq_req;
   div_req_type        div_req;
   logic               sq_done, div_done;
   logic [SQ_OUT_W-1:0] sq_root;
   logic [DIV_N_W-1:0] quo;
   logic signed [16:0] uvx, uvy;
   logic [16:0]        uvx_mag, uvy_mag;
   logic signed [15:0] uq;
   logic [31:0]        gap;
   logic signed [44:0] blend_v;
   logic signed [23:0] blend_sat;
   logic signed [39:0] lim_ext;

   // Differences and sums against the reference
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dh[i]   = 17'(hin_ff[i]) - 17'(lh_ff[i]);
         dv[i]   = 17'(vin_ff[i]) - 17'(lv_ff[i]);
         sm_h[i] = 17'(hin_ff[i]) + 17'(lh_ff[i]);
         sm_v[i] = 17'(vin_ff[i]) + 17'(lv_ff[i]);
      end
   end

   assign ki = (cnt_ff[1:0] == 2'd3) ? 2'd2 : cnt_ff[1:0];

   // Select the multiply-accumulate operation for this step
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_neg = 1'b0;
      op_shl = 1'b0;
      n_ops  = 3'd0;
      is_mac = 1'b1;
      unique case (state_ff)
         ST_DHSQ: begin
            n_ops = 3'd3;
            op_a  = MUL_W'(dh[ki]);
            op_b  = MUL_W'(dh[ki]);
         end
         ST_MT: begin
            n_ops = 3'd1;
            op_a  = MUL_W'(turn_ff);
            op_b  = MUL_W'(turn_ff);
         end
         ST_DVSQ: begin
            n_ops = 3'd3;
            op_a  = MUL_W'(dv[ki]);
            op_b  = MUL_W'(dv[ki]);
         end
         ST_UV_LEN: begin
            n_ops = 3'd2;
            op_a  = sel_ff ? MUL_W'(dh[ki]) : MUL_W'(dv[ki]);
            op_b  = op_a;
         end
         ST_CT: begin
            n_ops = 3'd2;
            op_a  = (cnt_ff == 3'd0) ? MUL_W'(ax_ff) : MUL_W'(ay_ff);
            op_b  = (cnt_ff == 3'd0) ? MUL_W'(bx_ff) : MUL_W'(by_ff);
         end
         ST_ST: begin
            n_ops  = 3'd2;
            op_a   = (cnt_ff == 3'd0) ? MUL_W'(ay_ff) : MUL_W'(ax_ff);
            op_b   = (cnt_ff == 3'd0) ? MUL_W'(bx_ff) : MUL_W'(by_ff);
            op_neg = (cnt_ff != 3'd0);
         end
         ST_R: begin
            n_ops = 3'd2;
            if (comp_ff == 2'd0) begin
               op_a   = (cnt_ff == 3'd0) ? MUL_W'(ct_ff) : MUL_W'(st_ff);
               op_b   = (cnt_ff == 3'd0) ? MUL_W'(sm_h[0]) : MUL_W'(sm_h[1]);
               op_neg = (cnt_ff != 3'd0);
            end else if (comp_ff == 2'd1) begin
               op_a = (cnt_ff == 3'd0) ? MUL_W'(st_ff) : MUL_W'(ct_ff);
               op_b = (cnt_ff == 3'd0) ? MUL_W'(sm_h[0]) : MUL_W'(sm_h[1]);
            end else if (cnt_ff == 3'd0) begin
               op_a = MUL_W'(sm_h[2]);
               op_b = ONE_Q14;
            end
         end
         ST_C: begin
            n_ops = 3'd3;
            if (cnt_ff == 3'd0) begin
               op_a   = MUL_W'(sm_v[comp_ff]);
               op_b   = SH_Q12;
               op_shl = 1'b1;
            end else begin
               op_a   = MUL_W'(sog_ff);
               op_b   = (cnt_ff == 3'd1) ? MUL_W'(r_ff[15:0])
                                         : MUL_W'($signed(r_ff[32:16]));
               op_neg = 1'b1;
               op_shl = (cnt_ff != 3'd1);
            end
         end
         ST_WSQ: begin
            n_ops = 3'd3;
            op_a  = MUL_W'(w_ff[ki]);
            op_b  = MUL_W'(w_ff[ki]);
         end
         ST_CSQ: begin
            n_ops = 3'd4;
            if (cnt_ff == 3'd3) begin
               op_a   = lim_ff;
               op_b   = lim_ff;
               op_neg = 1'b1;
            end else begin
               op_a = c_ff[ki][MUL_W-1:0];
               op_b = c_ff[ki][MUL_W-1:0];
            end
         end
         ST_BLEND: begin
            n_ops = 3'd2;
            if (cnt_ff == 3'd0) begin
               op_a = MUL_W'(w_ff[comp_ff]);
               op_b = ONE_Q15 - MUL_W'(gain_ff);
            end else begin
               op_a = c_ff[comp_ff][MUL_W-1:0];
               op_b = MUL_W'(gain_ff);
            end
         end
         ST_HSQ: begin
            n_ops = 3'd2;
            op_a  = MUL_W'(w_ff[ki]);
            op_b  = MUL_W'(w_ff[ki]);
         end
         default: begin
            is_mac = 1'b0;
         end
      endcase
      mac_done = is_mac && (cnt_ff == n_ops + 3'd1);
      mac_cmd.valid = is_mac && (cnt_ff < n_ops);
      mac_cmd.clr   = (cnt_ff == 3'd0);
      mac_cmd.neg   = op_neg;
      mac_cmd.shl   = op_shl;
      mac_cmd.a     = op_a;
      mac_cmd.b     = op_b;
   end

   // Decisions and rounding of unit results
   always_comb begin
      gap        = now_ff - lt_ff;
      turn_small = (dhsq_ff <= acc[35:0]);
      uvx        = sel_ff ? dh[0] : dv[0];
      uvy        = sel_ff ? dh[1] : dv[1];
      uvx_mag    = uvx[16] ? 17'(-uvx) : 17'(uvx);
      uvy_mag    = uvy[16] ? 17'(-uvy) : 17'(uvy);
      uq         = 16'(quo[15:0]);
      lim_ext    = $signed({13'b0, lim_ff});
      lim_fail   = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if ((40'(c_ff[i]) >= lim_ext) || (-40'(c_ff[i]) >= lim_ext)) begin
            lim_fail = 1'b1;
         end
      end
      blend_v = acc[ACC_W-1:15];
      if (blend_v > 45'(W_MAX)) begin
         blend_sat = W_MAX;
      end else if (blend_v < 45'(W_MIN)) begin
         blend_sat = W_MIN;
      end else begin
         blend_sat = blend_v[23:0];
      end
      can_load = !rsp_valid_ff || rsp_ready;
   end

   // Start the shared root and divide units
   always_comb begin
      sq_req  = '0;
      div_req = '0;
      unique case (state_ff)
         ST_MT: begin
            if (mac_done && !turn_small) begin
               sq_req.start = 1'b1;
               sq_req.x     = SQ_IN_W'(dhsq_ff);
            end
         end
         ST_DVSQ, ST_UV_LEN, ST_WSQ, ST_HSQ: begin
            if (mac_done) begin
               sq_req.start = 1'b1;
               sq_req.x     = acc[SQ_IN_W-1:0];
            end
         end
         ST_SQ_DV: begin
            if (sq_done) begin
               div_req.start    = 1'b1;
               div_req.dividend = {sq_root[16:0], 14'b0};
               div_req.divisor  = dhl_ff;
            end
         end
         ST_UV_SQ: begin
            if (sq_done && (sq_root != '0)) begin
               div_req.start    = 1'b1;
               div_req.dividend = {uvx_mag, 14'b0};
               div_req.divisor  = sq_root[16:0];
            end
         end
         ST_UV_DX: begin
            if (div_done) begin
               div_req.start    = 1'b1;
               div_req.dividend = {uvy_mag, 14'b0};
               div_req.divisor  = len_ff;
            end
         end
         default: begin
         end
      endcase
   end

   wve_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .acc   (acc)
   );

   wve_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sq_req),
      .done  (sq_done),
      .root  (sq_root)
   );

   wve_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quo   (quo)
   );

   // Sequencer, registers and estimator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         comp_ff      <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RST;
         turn_ff      <= TURN_RST;
         margin_ff    <= MARGIN_RST;
         gain_ff      <= GAIN_RST;
         lt_ff        <= '0;
         hw_ff        <= '0;
         for (int i = 0; i < 3; i++) begin
            lh_ff[i] <= '0;
            lv_ff[i] <= '0;
            w_ff[i]  <= '0;
         end
      end else begin
         // Register writes
         if (csr_valid) begin
            unique case (csr_index)
               CSR_TIMEOUT: timeout_ff <= csr_data;
               CSR_TURN:    turn_ff    <= csr_data;
               CSR_MARGIN:  margin_ff  <= csr_data[14:0];
               CSR_GAIN:    gain_ff    <= csr_data;
            endcase
         end

         // Drop the result once taken
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // Step counter for multiply-accumulate phases
         if (mac_done || !is_mac) begin
            cnt_ff <= '0;
         end else begin
            cnt_ff <= cnt_ff + 3'd1;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (gap > 32'(timeout_ff)) begin
                  lt_ff <= now_ff;
                  for (int i = 0; i < 3; i++) begin
                     lh_ff[i] <= hin_ff[i];
                     lv_ff[i] <= vin_ff[i];
                  end
                  state_ff <= ST_FIN;
               end else begin
                  state_ff <= ST_DHSQ;
               end
            end
            ST_DHSQ: if (mac_done) state_ff <= ST_MT;
            ST_MT: begin
               if (mac_done) begin
                  state_ff <= turn_small ? ST_FIN : ST_SQ_DH;
               end
            end
            ST_SQ_DH: if (sq_done) state_ff <= ST_DVSQ;
            ST_DVSQ: if (mac_done) state_ff <= ST_SQ_DV;
            ST_SQ_DV: if (sq_done) state_ff <= ST_DIV_SOG;
            ST_DIV_SOG: begin
               if (div_done) begin
                  sel_ff   <= 1'b0;
                  state_ff <= ST_UV_LEN;
               end
            end
            ST_UV_LEN: if (mac_done) state_ff <= ST_UV_SQ;
            ST_UV_SQ: begin
               if (sq_done) begin
                  if (sq_root != '0) begin
                     state_ff <= ST_UV_DX;
                  end else if (sel_ff) begin
                     state_ff <= ST_CT;
                  end else begin
                     sel_ff   <= 1'b1;
                     state_ff <= ST_UV_LEN;
                  end
               end
            end
            ST_UV_DX: if (div_done) state_ff <= ST_UV_DY;
            ST_UV_DY: begin
               if (div_done) begin
                  if (sel_ff) begin
                     state_ff <= ST_CT;
                  end else begin
                     sel_ff   <= 1'b1;
                     state_ff <= ST_UV_LEN;
                  end
               end
            end
            ST_CT: if (mac_done) state_ff <= ST_ST;
            ST_ST: begin
               if (mac_done) begin
                  comp_ff  <= '0;
                  state_ff <= ST_R;
               end
            end
            ST_R: if (mac_done) state_ff <= ST_C;
            ST_C: begin
               if (mac_done) begin
                  if (comp_ff == 2'd2) begin
                     comp_ff  <= '0;
                     state_ff <= ST_WSQ;
                  end else begin
                     comp_ff  <= comp_ff + 2'd1;
                     state_ff <= ST_R;
                  end
               end
            end
            ST_WSQ: if (mac_done) state_ff <= ST_SQ_W;
            ST_SQ_W: if (sq_done) state_ff <= ST_LIM;
            ST_LIM: state_ff <= lim_fail ? ST_UPD : ST_CSQ;
            ST_CSQ: begin
               if (mac_done) begin
                  comp_ff  <= '0;
                  state_ff <= acc[ACC_W-1] ? ST_BLEND : ST_UPD;
               end
            end
            ST_BLEND: begin
               if (mac_done) begin
                  w_ff[comp_ff] <= blend_sat;
                  if (comp_ff == 2'd2) begin
                     comp_ff  <= '0;
                     state_ff <= ST_UPD;
                  end else begin
                     comp_ff <= comp_ff + 2'd1;
                  end
               end
            end
            ST_UPD: begin
               lt_ff <= now_ff;
               for (int i = 0; i < 3; i++) begin
                  lh_ff[i] <= hin_ff[i];
                  lv_ff[i] <= vin_ff[i];
               end
               state_ff <= ST_HSQ;
            end
            ST_HSQ: if (mac_done) state_ff <= ST_SQ_H;
            ST_SQ_H: begin
               if (sq_done) begin
                  hw_ff    <= (sq_root[25:24] != 2'b00) ? 16'hFFFF : sq_root[23:8];
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (can_load) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Working registers and result payload
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               hin_ff[0] <= req_head_north;
               hin_ff[1] <= req_head_east;
               hin_ff[2] <= req_head_down;
               vin_ff[0] <= req_vel_north;
               vin_ff[1] <= req_vel_east;
               vin_ff[2] <= req_vel_down;
               now_ff    <= req_now_ms;
            end
         end
         ST_CHECK: outcome_ff <= OUT_REBASE;
         ST_DHSQ: if (mac_done) dhsq_ff <= acc[35:0];
         ST_MT: if (mac_done) outcome_ff <= OUT_SMALL;
         ST_SQ_DH: if (sq_done) dhl_ff <= sq_root[16:0];
         ST_DIV_SOG: begin
            if (div_done) begin
               sog_ff <= (quo[30:24] != '0) ? 24'hFFFFFF : quo[23:0];
            end
         end
         ST_UV_SQ: begin
            if (sq_done) begin
               len_ff <= sq_root[16:0];
               if (sq_root == '0) begin
                  if (sel_ff) begin
                     bx_ff <= 16'sd16384;
                     by_ff <= '0;
                  end else begin
                     ax_ff <= 16'sd16384;
                     ay_ff <= '0;
                  end
               end
            end
         end
         ST_UV_DX: begin
            if (div_done) begin
               if (sel_ff) begin
                  bx_ff <= uvx[16] ? -uq : uq;
               end else begin
                  ax_ff <= uvx[16] ? -uq : uq;
               end
            end
         end
         ST_UV_DY: begin
            if (div_done) begin
               if (sel_ff) begin
                  by_ff <= uvy[16] ? -uq : uq;
               end else begin
                  ay_ff <= uvy[16] ? -uq : uq;
               end
            end
         end
         ST_CT: if (mac_done) ct_ff <= acc[29:14];
         ST_ST: if (mac_done) st_ff <= acc[29:14];
         ST_R: if (mac_done) r_ff <= acc[32:0];
         ST_C: if (mac_done) c_ff[comp_ff] <= acc[ACC_W-1:21];
         ST_SQ_W: begin
            if (sq_done) begin
               lim_ff <= 27'(sq_root) + 27'({margin_ff, 8'b0});
            end
         end
         ST_LIM: outcome_ff <= OUT_REJECT;
         ST_BLEND: if (mac_done && (comp_ff == 2'd2)) outcome_ff <= OUT_BLEND;
         ST_FIN: begin
            if (can_load) begin
               rsp_wn_ff  <= w_ff[0][23:8];
               rsp_we_ff  <= w_ff[1][23:8];
               rsp_wd_ff  <= w_ff[2][23:8];
               rsp_hw_ff  <= hw_ff;
               rsp_out_ff <= outcome_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_wind_north      = rsp_wn_ff;
   assign rsp_wind_east       = rsp_we_ff;
   assign rsp_wind_down       = rsp_wd_ff;
   assign rsp_wind_horizontal = rsp_hw_ff;
   assign rsp_outcome         = rsp_out_ff;

endmodule

### src/wve_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate.
module wve_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  wve_pkg::mac_cmd_type              cmd,
   output logic signed [wve_pkg::ACC_W-1:0]  acc
);
   import wve_pkg::*;

   logic signed [PROD_W-1:0] p_ff;
   logic                     vld_ff, clr_ff, neg_ff, shl_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, p_ext, term, base;

   // Register the product and its accumulate controls
   always_ff @(posedge clock) begin
      p_ff   <= cmd.a * cmd.b;
      clr_ff <= cmd.clr;
      neg_ff <= cmd.neg;
      shl_ff <= cmd.shl;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= cmd.valid;
      end
   end

   // Add or subtract the product, optionally shifted up
   always_comb begin
      p_ext  = ACC_W'(p_ff);
      term   = shl_ff ? (p_ext <<< SHL_N) : p_ext;
      base   = clr_ff ? '0 : acc_ff;
      acc_in = neg_ff ? (base - term) : (base + term);
   end

   always_ff @(posedge clock) begin
      if (vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

### src/wve_sqrt.sv
// Shared floor square root, one result bit per cycle.
module wve_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  wve_pkg::sqrt_req_type           req,
   output logic                            done,
   output logic [wve_pkg::SQ_OUT_W-1:0]    root
);
   import wve_pkg::*;

   localparam int CNT_W = $clog2(SQ_OUT_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(SQ_OUT_W - 1);

   logic [SQ_IN_W-1:0]  x_ff;
   logic [SQ_OUT_W+1:0] rem_ff;
   logic [SQ_OUT_W-1:0] root_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                busy_ff, done_ff;
   logic [SQ_OUT_W+3:0] rem_sh, trial, diff;
   logic                ge;

   // Bring down two bits and try the next root bit
   always_comb begin
      rem_sh = {rem_ff, x_ff[SQ_IN_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      ge     = (rem_sh >= trial);
      diff   = rem_sh - trial;
   end

   // Advance the control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Shift the operand and build the root
   always_ff @(posedge clock) begin
      if (req.start) begin
         x_ff    <= req.x;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         x_ff    <= x_ff << 2;
         rem_ff  <= ge ? diff[SQ_OUT_W+1:0] : rem_sh[SQ_OUT_W+1:0];
         root_ff <= {root_ff[SQ_OUT_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### src/wve_div.sv
// Shared unsigned restoring divider, one quotient bit per cycle.
module wve_div (
   input  logic                           clock,
   input  logic                           reset,
   input  wve_pkg::div_req_type           req,
   output logic                           done,
   output logic [wve_pkg::DIV_N_W-1:0]    quo
);
   import wve_pkg::*;

   localparam int CNT_W = $clog2(DIV_N_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_N_W - 1);

   logic [DIV_N_W-1:0] dd_ff;
   logic [DIV_D_W-1:0] rem_ff, dv_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff, done_ff;
   logic [DIV_D_W:0]   rem_sh, diff;
   logic               ge;

   // Bring down one dividend bit and trial-subtract
   always_comb begin
      rem_sh = {rem_ff, dd_ff[DIV_N_W-1]};
      ge     = (rem_sh >= {1'b0, dv_ff});
      diff   = rem_sh - {1'b0, dv_ff};
   end

   // Advance the control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Shift quotient bits in where dividend bits leave
   always_ff @(posedge clock) begin
      if (req.start) begin
         dd_ff  <= req.dividend;
         dv_ff  <= req.divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dd_ff  <= {dd_ff[DIV_N_W-2:0], ge};
         rem_ff <= ge ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
      end
   end

   assign done = done_ff;
   assign quo  = dd_ff;

endmodule

### sim/wve_checker.sv
// Wind estimate predictor and response checker for the wind vector estimator.
module wve_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_head_north,
   input  logic signed [15:0] req_head_east,
   input  logic signed [15:0] req_head_down,
   input  logic signed [15:0] req_vel_north,
   input  logic signed [15:0] req_vel_east,
   input  logic signed [15:0] req_vel_down,
   input  logic        [31:0] req_now_ms,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_wind_north,
   input  logic signed [15:0] rsp_wind_east,
   input  logic signed [15:0] rsp_wind_down,
   input  logic        [15:0] rsp_wind_horizontal,
   input  logic        [1:0]  rsp_outcome,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic        [1:0]  csr_index,
   input  logic        [15:0] csr_data,
   output int                 fails,
   output int                 pending
);
   import wve_pkg::*;

   typedef struct packed {
      logic [15:0] wind_n;
      logic [15:0] wind_e;
      logic [15:0] wind_d;
      logic [15:0] horiz;
      logic [1:0]  outcome;
   } wind_result_type;

   wind_result_type wind_expected_q[$];

   // Predictor copy of the registers and state
   logic [15:0] timeout_ms;
   logic [15:0] turn_min;
   logic [14:0] margin;
   logic [15:0] gain;
   longint      ref_head[3];
   longint      ref_vel[3];
   longint      wind_q816[3];
   logic [31:0] ref_time;
   logic [15:0] horiz_wind;

   assign pending = wind_expected_q.size();

   // Floor square root of a 64-bit value
   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Horizontal unit vector in Q1.14, truncated toward zero
   function automatic void unit_horiz(longint x, longint y, output longint ux,
                                      output longint uy);
      longint l;
      l = longint'(floor_sqrt(x * x + y * y));
      if (l == 0) begin
         ux = 16384;
         uy = 0;
      end else begin
         ux = (x * 16384) / l;
         uy = (y * 16384) / l;
      end
   endfunction

   // Advance the predicted state by one request and return the result
   function automatic wind_result_type estimate_wind(longint h[3], longint v[3],
                                                     logic [31:0] now);
      wind_result_type res;
      longint dh[3], dv[3], hs[3], vs[3], cand[3], rot[3];
      longint ax, ay, bx, by, ct, st, sg, wl, lim, wn, g;
      logic [63:0] dhsq, dvsq, csq, wsq, sog, hq;
      logic [31:0] gap;
      logic ok;
      gap = now - ref_time;
      if (gap > {16'd0, timeout_ms}) begin
         ref_time = now;
         for (int i = 0; i < 3; i++) begin
            ref_head[i] = h[i];
            ref_vel[i] = v[i];
         end
         res.outcome = OUT_REBASE;
      end else begin
         dhsq = 0;
         dvsq = 0;
         for (int i = 0; i < 3; i++) begin
            dh[i] = h[i] - ref_head[i];
            dv[i] = v[i] - ref_vel[i];
            hs[i] = h[i] + ref_head[i];
            vs[i] = v[i] + ref_vel[i];
            dhsq += dh[i] * dh[i];
            dvsq += dv[i] * dv[i];
         end
         if (dhsq <= 64'(turn_min) * 64'(turn_min)) begin
            res.outcome = OUT_SMALL;
         end else begin
            sog = (floor_sqrt(dvsq) << 14) / floor_sqrt(dhsq);
            if (sog > 64'hFFFFFF) sog = 64'hFFFFFF;
            unit_horiz(dv[0], dv[1], ax, ay);
            unit_horiz(dh[0], dh[1], bx, by);
            ct = (ax * bx + ay * by) >>> 14;
            st = (ay * bx - ax * by) >>> 14;
            rot[0] = ct * hs[0] - st * hs[1];
            rot[1] = st * hs[0] + ct * hs[1];
            rot[2] = hs[2] * 16384;
            sg = longint'(sog);
            wsq = 0;
            for (int i = 0; i < 3; i++) begin
               cand[i] = (vs[i] * (longint'(1) <<< 28) - sg * rot[i]) >>> 21;
               wsq += wind_q816[i] * wind_q816[i];
            end
            wl = longint'(floor_sqrt(wsq));
            lim = wl + longint'(margin) * 256;
            ok = 1'b1;
            for (int i = 0; i < 3; i++)
               if (cand[i] >= lim || -cand[i] >= lim) ok = 1'b0;
            if (ok) begin
               csq = 0;
               for (int i = 0; i < 3; i++) csq += cand[i] * cand[i];
               if (csq >= 64'(lim * lim)) ok = 1'b0;
            end
            if (ok) begin
               g = longint'(gain);
               for (int i = 0; i < 3; i++) begin
                  wn = (wind_q816[i] * (32768 - g) + cand[i] * g) >>> 15;
                  if (wn < -8388608) wn = -8388608;
                  if (wn > 8388607) wn = 8388607;
                  wind_q816[i] = wn;
               end
               res.outcome = OUT_BLEND;
            end else begin
               res.outcome = OUT_REJECT;
            end
            for (int i = 0; i < 3; i++) begin
               ref_head[i] = h[i];
               ref_vel[i] = v[i];
            end
            ref_time = now;
            hq = floor_sqrt(wind_q816[0] * wind_q816[0] + wind_q816[1] * wind_q816[1]) >> 8;
            horiz_wind = (hq > 64'd65535) ? 16'hFFFF : hq[15:0];
         end
      end
      res.wind_n = 16'(wind_q816[0] >>> 8);
      res.wind_e = 16'(wind_q816[1] >>> 8);
      res.wind_d = 16'(wind_q816[2] >>> 8);
      res.horiz = horiz_wind;
      return res;
   endfunction

   // Compare one field and count a mismatch
   function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
         fails++;
      end
   endfunction

   // Track register writes, predict on request transfers, check response transfers
   always @(posedge clock) begin
      longint h[3], v[3];
      wind_result_type exp_r;
      if (reset) begin
         timeout_ms <= TIMEOUT_RST;
         turn_min <= TURN_RST;
         margin <= MARGIN_RST;
         gain <= GAIN_RST;
         for (int i = 0; i < 3; i++) begin
            ref_head[i] = 0;
            ref_vel[i] = 0;
            wind_q816[i] = 0;
         end
         ref_time = 0;
         horiz_wind = 0;
         wind_expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_TIMEOUT: timeout_ms <= csr_data;
               CSR_TURN:    turn_min <= csr_data;
               CSR_MARGIN:  margin <= csr_data[14:0];
               CSR_GAIN:    gain <= csr_data;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (wind_expected_q.size() == 0) begin
               $display("%0t: response with no request waiting, actual %h", $realtime,
                        {rsp_wind_north, rsp_wind_east, rsp_wind_down,
                         rsp_wind_horizontal, rsp_outcome});
               fails++;
            end else begin
               exp_r = wind_expected_q.pop_front();
               check_field("wind_north", exp_r.wind_n, rsp_wind_north);
               check_field("wind_east", exp_r.wind_e, rsp_wind_east);
               check_field("wind_down", exp_r.wind_d, rsp_wind_down);
               check_field("wind_horizontal", exp_r.horiz, rsp_wind_horizontal);
               check_field("outcome", {14'd0, exp_r.outcome}, {14'd0, rsp_outcome});
            end
         end
         if (req_valid && req_ready) begin
            h[0] = req_head_north;
            h[1] = req_head_east;
            h[2] = req_head_down;
            v[0] = req_vel_north;
            v[1] = req_vel_east;
            v[2] = req_vel_down;
            wind_expected_q.push_back(estimate_wind(h, v, req_now_ms));
         end
      end
   end

endmodule

### sim/tb.sv
// Testbench top for the wind vector estimator: stimulus, idling and verdict.
module tb;
   import wve_pkg::*;

   localparam int CYCLE_LIMIT = 6000000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_head_north;
   logic signed [15:0] req_head_east;
   logic signed [15:0] req_head_down;
   logic signed [15:0] req_vel_north;
   logic signed [15:0] req_vel_east;
   logic signed [15:0] req_vel_down;
   logic        [31:0] req_now_ms;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_wind_north;
   logic signed [15:0] rsp_wind_east;
   logic signed [15:0] rsp_wind_down;
   logic        [15:0] rsp_wind_horizontal;
   logic        [1:0]  rsp_outcome;
   logic               csr_valid;
   logic               csr_ready;
   logic        [1:0]  csr_index;
   logic        [15:0] csr_data;
   int                 fails;
   int                 pending;
   int                 cycles;
   bit                 idle_on;
   logic        [31:0] clock_ms;

   wind_vector_estimator_top i_dut (.*);

   wve_checker i_checker (.*);

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // Drop response ready at random while idling is on
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !(idle_on && $urandom_range(99) < 29);
   end

   // Send one request transfer; valid stays high between back-to-back items
   task automatic send_item(int hn, int he, int hd, int vn, int ve, int vd,
                            logic [31:0] now);
      while (idle_on && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_head_north <= 16'(hn);
      req_head_east <= 16'(he);
      req_head_down <= 16'(hd);
      req_vel_north <= 16'(vn);
      req_vel_east <= 16'(ve);
      req_vel_down <= 16'(vd);
      req_now_ms <= now;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold until every expected response has come, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(logic [15:0] tmo, logic [15:0] turn, logic [15:0] mrg,
                            logic [15:0] g);
      write_reg(CSR_TIMEOUT, tmo);
      write_reg(CSR_TURN, turn);
      write_reg(CSR_MARGIN, mrg);
      write_reg(CSR_GAIN, g);
   endtask

   // Random items: mostly close-in-time turns with modest velocities
   task automatic random_items(int count);
      int hn, he, hd, vn, ve, vd, sel;
      for (int n = 0; n < count; n++) begin
         hn = int'($urandom_range(32768)) - 16384;
         he = int'($urandom_range(32768)) - 16384;
         hd = int'($urandom_range(8192)) - 4096;
         if ($urandom_range(99) < 10) hd = int'($urandom_range(32768)) - 16384;
         if ($urandom_range(99) < 70) begin
            vn = int'($urandom_range(3000)) - 1500;
            ve = int'($urandom_range(3000)) - 1500;
            vd = int'($urandom_range(600)) - 300;
         end else begin
            vn = int'($urandom_range(65535)) - 32768;
            ve = int'($urandom_range(65535)) - 32768;
            vd = int'($urandom_range(65535)) - 32768;
         end
         sel = $urandom_range(99);
         if (sel < 85) clock_ms = clock_ms + $urandom_range(900);
         else if (sel < 95) clock_ms = clock_ms + $urandom_range(70000, 1000);
         else clock_ms = $urandom;
         send_item(hn, he, hd, vn, ve, vd, clock_ms);
      end
   endtask

   initial begin
      cycles = 0;
      idle_on = 1'b1;
      clock_ms = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_head_north = '0;
      req_head_east = '0;
      req_head_down = '0;
      req_vel_north = '0;
      req_vel_east = '0;
      req_vel_down = '0;
      req_now_ms = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset defaults, field extremes and each outcome
      send_item(16384, 0, 0, 256, 0, 0, 0);
      send_item(16384, 0, 0, 256, 0, 0, 10);
      send_item(0, 16384, 0, 0, 512, 0, 20);
      send_item(-16384, 0, 0, -256, 100, 0, 30);
      send_item(0, -16384, 0, 10, -300, 50, 40);
      send_item(0, -16384, 16384, 10, -300, 50, 50);
      send_item(0, -16384, -16384, 10, -300, -50, 60);
      send_item(16384, 16384, 16384, 32767, 32767, 32767, 70);
      send_item(-16384, -16384, -16384, -32768, -32768, -32768, 80);
      send_item(16384, 0, 0, 0, 0, 0, 90);
      send_item(0, 16384, 0, 0, 0, 0, 100);
      send_item(0, 16384, 0, 0, 0, 0, 1101);
      send_item(0, 16384, 0, 0, 0, 0, 32'hFFFFFFFF);
      send_item(16384, 0, 0, 200, 100, 0, 500);
      send_item(11585, 11585, 0, 300, 150, 0, 600);
      send_item(0, 16384, 0, 250, 400, 0, 700);
      send_item(-11585, 11585, 0, 100, 350, 10, 800);
      send_item(-16384, 0, 0, 0, 0, -32768, 900);
      drain();
      clock_ms = 900;

      // Random phases across register settings
      write_all(16'd1000, 16'd3277, 16'd5120, 16'd1638);
      random_items(400);
      drain();
      write_all(16'd65535, 16'd0, 16'd32767, 16'd32768);
      random_items(400);
      drain();
      write_all(16'd0, 16'd32768, 16'd0, 16'd0);
      random_items(150);
      drain();
      write_all(16'd2000, 16'd1000, 16'd32767, 16'd65535);
      random_items(450);
      drain();
      idle_on = 1'b0;
      write_all(16'd1500, 16'd2000, 16'd20000, 16'd8000);
      random_items(300);
      idle_on = 1'b1;
      random_items(300);

      drain();
      repeat (500) @(posedge clock);
      if (fails == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

endmodule

### files.f
src/wve_pkg.sv
src/wve_mac.sv
src/wve_sqrt.sv
src/wve_div.sv
src/wind_vector_estimator_top.sv
sim/wve_checker.sv
sim/tb.sv
